### hdl/assert_macros.svh
// Assertion shorthands used by the RTL design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/e2c_pkg.sv
package e2c_pkg;

  localparam int SecsW   = 32;
  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;

  localparam logic [YearW-1:0]   BaseYear   = YearW'(1970);
  localparam logic [YearW-1:0]   LastYear   = YearW'(2106);
  localparam logic [YearW-1:0]   NonLeapCentury = YearW'(2100);
  localparam logic [MonthW-1:0]  LastMonth  = MonthW'(12);

  localparam logic [SecsW-1:0] SecsPerMin     = SecsW'(60);
  localparam logic [SecsW-1:0] SecsPerHour    = SecsW'(60 * 60);
  localparam logic [SecsW-1:0] SecsPerDay     = SecsW'(24 * 60 * 60);
  localparam logic [SecsW-1:0] SecsLeapYear   = SecsW'(366 * 24 * 60 * 60);
  localparam logic [SecsW-1:0] SecsCommonYear = SecsW'(365 * 24 * 60 * 60);

  // Result of the shared compare/subtract unit
  typedef struct packed {
    logic             fits;   // minuend >= subtrahend
    logic [SecsW-1:0] diff;
  } sub_res_t;

  // Gregorian leap rule over the reachable span 1970..2106: the only century
  // years are 2000 (leap, divisible by 400) and 2100 (not leap).
  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y[1:0] == 2'b00) && (y != NonLeapCentury);
  endfunction

  // Length of a month in seconds; month is 1-based
  function automatic logic [SecsW-1:0] month_secs(input logic leap,
                                                  input logic [MonthW-1:0] m);
    logic [SecsW-1:0] secs;
    case (m)
      MonthW'(2):  secs = leap ? SecsW'(29 * 24 * 60 * 60) : SecsW'(28 * 24 * 60 * 60);
      MonthW'(4),
      MonthW'(6),
      MonthW'(9),
      MonthW'(11): secs = SecsW'(30 * 24 * 60 * 60);
      default:     secs = SecsW'(31 * 24 * 60 * 60);
    endcase
    return secs;
  endfunction

endpackage

### hdl/e2c_in_if.sv
interface e2c_in_if;
  import e2c_pkg::*;

  logic             valid;
  logic             ready;
  logic [SecsW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

### hdl/e2c_out_if.sv
interface e2c_out_if;
  import e2c_pkg::*;

  logic               valid;
  logic               ready;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day;
  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;
  logic [SecondW-1:0] second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

### hdl/e2c_sub_unit.sv
// Shared 32-bit compare and subtract: one borrow chain gives both answers.
module e2c_sub_unit (
  input  logic [e2c_pkg::SecsW-1:0] minuend,
  input  logic [e2c_pkg::SecsW-1:0] subtrahend,
  output e2c_pkg::sub_res_t         res
);
  import e2c_pkg::*;

  logic [SecsW:0] wide_diff;

  assign wide_diff = {1'b0, minuend} - {1'b0, subtrahend};
  assign res.fits  = ~wide_diff[SecsW];
  assign res.diff  = wide_diff[SecsW-1:0];

endmodule

### hdl/epoch_seconds_to_calendar.sv
// Channel  | Dir | Fields                                   | Handshake
// ---------+-----+------------------------------------------+-------------
// in_ch    | in  | epoch_seconds[31:0]                      | valid/ready
// out_ch   | out | year, month, day, hour, minute, second   | valid/ready
//
// A word is accepted in S_IDLE; each of the five steps then takes off whole years,
// months, days, hours or minutes while the remainder still fits, and S_DONE
// loads the result into the output register.
// All steps run through one 32-bit compare/subtract unit.
// in_ch.ready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next word can enter while it waits.
// Finishing stalls while the output register still holds an untaken result.
// Reset (rst, synchronous) returns to idle and drops out_ch.valid.
module epoch_seconds_to_calendar (
  input  logic clk,
  input  logic rst,
  e2c_in_if.sink    in_ch,
  e2c_out_if.source out_ch
);
  import e2c_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_DONE
  } state_t;

  state_t             state;
  logic [SecsW-1:0]   rem;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day;
  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;

  logic               out_valid;
  logic [YearW-1:0]   out_year;
  logic [MonthW-1:0]  out_month;
  logic [DayW-1:0]    out_day;
  logic [HourW-1:0]   out_hour;
  logic [MinuteW-1:0] out_minute;
  logic [SecondW-1:0] out_second;

  logic [SecsW-1:0]   amount;
  sub_res_t           sub;
  logic               leap;

  assign leap = is_leap(year);

  // Amount to take off in the current step
  always_comb begin
    case (state)
      S_YEAR:  amount = leap ? SecsLeapYear : SecsCommonYear;
      S_MONTH: amount = month_secs(leap, month);
      S_DAY:   amount = SecsPerDay;
      S_HOUR:  amount = SecsPerHour;
      S_MIN:   amount = SecsPerMin;
      default: amount = '0;
    endcase
  end

  e2c_sub_unit u_sub (
    .minuend    (rem),
    .subtrahend (amount),
    .res        (sub)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result taken; a finishing word reloads the register below instead
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            rem    <= in_ch.epoch_seconds;
            year   <= BaseYear;
            month  <= MonthW'(1);
            day    <= DayW'(1);
            hour   <= '0;
            minute <= '0;
            state  <= S_YEAR;
          end
        end
        S_YEAR: begin
          if (sub.fits) begin
            rem  <= sub.diff;
            year <= year + YearW'(1);
          end else begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (sub.fits && (month != LastMonth)) begin
            rem   <= sub.diff;
            month <= month + MonthW'(1);
          end else begin
            state <= S_DAY;
          end
        end
        S_DAY: begin
          if (sub.fits) begin
            rem <= sub.diff;
            day <= day + DayW'(1);
          end else begin
            state <= S_HOUR;
          end
        end
        S_HOUR: begin
          if (sub.fits) begin
            rem  <= sub.diff;
            hour <= hour + HourW'(1);
          end else begin
            state <= S_MIN;
          end
        end
        S_MIN: begin
          if (sub.fits) begin
            rem    <= sub.diff;
            minute <= minute + MinuteW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_year   <= year;
            out_month  <= month;
            out_day    <= day;
            out_hour   <= hour;
            out_minute <= minute;
            out_second <= rem[SecondW-1:0];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready   = (state == S_IDLE);
  assign out_ch.valid  = out_valid;
  assign out_ch.year   = out_year;
  assign out_ch.month  = out_month;
  assign out_ch.day    = out_day;
  assign out_ch.hour   = out_hour;
  assign out_ch.minute = out_minute;
  assign out_ch.second = out_second;

  // Remainder must shrink below each unit before the next step starts
  `ASSERT_CLK(a_hour_rem, (state == S_HOUR) |-> (rem < SecsPerDay), "day step left a full day")
  `ASSERT_CLK(a_min_rem, (state == S_MIN) |-> (rem < SecsPerHour), "hour step left a full hour")
  `ASSERT_CLK(a_done_rem, (state == S_DONE) |-> (rem < SecsPerMin), "minute step left a minute")
  `ASSERT_CLK(a_year_span, (state != S_IDLE) |-> (year <= LastYear), "year ran past 2106")
  `ASSERT_CLK(a_start, (in_ch.valid && in_ch.ready) |=> (state == S_YEAR), "word not started")
  `ASSERT_ALWAYS(a_rst_out, $past(rst) |-> !out_ch.valid, "result valid right after reset")

endmodule
